>>> rtl/ffea_pkg.sv
package ffea_pkg;

  // Table geometry.
  localparam int unsigned MAX_EXTENTS = 256;
  localparam int unsigned IDX_W       = $clog2(MAX_EXTENTS);
  localparam int unsigned CNT_W       = $clog2(MAX_EXTENTS + 1);

  // Field widths.
  localparam int unsigned PAGE_W = 20;
  localparam int unsigned LEN_W  = 21;
  localparam int unsigned ALU_W  = LEN_W + 1;
  localparam int unsigned CFG_IDX_W = 1;

  // One past the highest page number.
  localparam logic [LEN_W-1:0] PAGE_TOP = LEN_W'(1) << PAGE_W;

  // Register reset values and the extent they give after reset.
  localparam logic [PAGE_W-1:0] RST_BASE  = PAGE_W'(786432);
  localparam logic [LEN_W-1:0]  RST_PAGES = LEN_W'(262144);
  localparam logic [LEN_W-1:0]  RST_ROOM  = PAGE_TOP - {1'b0, RST_BASE};
  localparam logic [LEN_W-1:0]  RST_LEN   = (RST_PAGES < RST_ROOM) ? RST_PAGES : RST_ROOM;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'b1;

  // Operation codes.
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [LEN_W-1:0]  page_count;
    logic [PAGE_W-1:0] free_page;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] address_page;
    logic [LEN_W-1:0]  used_pages;
  } rsp_t;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [LEN_W-1:0]  length;
  } ext_t;

  typedef struct packed {
    logic [PAGE_W-1:0] base;
    logic [LEN_W-1:0]  pages;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    ext_t             data;
  } ram_wr_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             ge;
    logic             eq;
  } alu_rsp_t;

  function automatic logic [ALU_W-1:0] zx_page(logic [PAGE_W-1:0] v);
    return {{(ALU_W - PAGE_W){1'b0}}, v};
  endfunction

  function automatic logic [ALU_W-1:0] zx_len(logic [LEN_W-1:0] v);
    return {{(ALU_W - LEN_W){1'b0}}, v};
  endfunction

endpackage

>>> rtl/ffea_alu.sv
// Shared add/subtract unit with unsigned compare flags.
module ffea_alu (
  input  ffea_pkg::alu_req_t req_i,
  output ffea_pkg::alu_rsp_t rsp_o
);

  logic [ffea_pkg::ALU_W:0] diff;

  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};

  always_comb begin
    if (req_i.op == ffea_pkg::ALU_SUB) begin
      rsp_o.res = diff[ffea_pkg::ALU_W-1:0];
    end else begin
      rsp_o.res = req_i.a + req_i.b;
    end
    rsp_o.ge = ~diff[ffea_pkg::ALU_W];
    rsp_o.eq = (req_i.a == req_i.b);
  end

endmodule

>>> rtl/ffea_extent_ram.sv
// Extent table: one write port, one read port with registered data.
module ffea_extent_ram (
  input  logic                       clk_i,
  input  ffea_pkg::ram_wr_t          wr_i,
  input  logic [ffea_pkg::IDX_W-1:0] raddr_i,
  output ffea_pkg::ext_t             rdata_o
);

  ffea_pkg::ext_t mem_q [ffea_pkg::MAX_EXTENTS];
  ffea_pkg::ext_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ffea_seq.sv
// Request sequencer: walks the extent table one entry at a time and drives
// the shared ALU and the table ports.
module ffea_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ffea_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ffea_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ffea_pkg::rsp_t             out_data_o,
  output ffea_pkg::ram_wr_t          ram_wr_o,
  output logic [ffea_pkg::IDX_W-1:0] ram_raddr_o,
  input  ffea_pkg::ext_t             ram_rdata_i,
  output ffea_pkg::alu_req_t         alu_req_o,
  input  ffea_pkg::alu_rsp_t         alu_rsp_i
);

  typedef enum logic [23:0] {
    S_BOOT      = 24'h000001,
    S_IDLE      = 24'h000002,
    S_INIT_ROOM = 24'h000004,
    S_INIT_CLIP = 24'h000008,
    S_CLIP_ROOM = 24'h000010,
    S_CLIP_LEN  = 24'h000020,
    S_SCAN_RD   = 24'h000040,
    S_SCAN_CHK  = 24'h000080,
    S_TRIM      = 24'h000100,
    S_JP_SUM    = 24'h000200,
    S_JP_CMP    = 24'h000400,
    S_JN_SUM    = 24'h000800,
    S_JN_CMP    = 24'h001000,
    S_MRG_A     = 24'h002000,
    S_MRG_B     = 24'h004000,
    S_MRG_P     = 24'h008000,
    S_MRG_N     = 24'h010000,
    S_DN_RD     = 24'h020000,
    S_DN_WR     = 24'h040000,
    S_UP_RD     = 24'h080000,
    S_UP_WR     = 24'h100000,
    S_USED_ADD  = 24'h200000,
    S_USED_SUB  = 24'h400000,
    S_DONE      = 24'h800000
  } state_e;

  localparam int unsigned CW = ffea_pkg::CNT_W;
  localparam int unsigned IW = ffea_pkg::IDX_W;
  localparam int unsigned LW = ffea_pkg::LEN_W;
  localparam int unsigned PW = ffea_pkg::PAGE_W;
  localparam int unsigned AW = ffea_pkg::ALU_W;

  state_e state_q, state_d;

  logic [CW-1:0] n_q, n_d;
  logic [LW-1:0] used_q, used_d;
  logic          out_vld_q, out_vld_d;

  logic [1:0]         op_q, op_d;
  logic [LW-1:0]      count_q, count_d;
  logic [PW-1:0]      page_q, page_d;
  logic [LW-1:0]      len_q, len_d;
  logic [AW-1:0]      tmp_q, tmp_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      j_q, j_d;
  logic [CW-1:0]      pos_q, pos_d;
  ffea_pkg::ext_t     prev_q, prev_d;
  ffea_pkg::ext_t     cur_q, cur_d;
  logic               cur_vld_q, cur_vld_d;
  logic               jp_q, jp_d;
  logic [1:0]         stat_q, stat_d;
  logic [PW-1:0]      addr_q, addr_d;
  ffea_pkg::rsp_t     out_q, out_d;

  logic          out_load;
  logic [CW-1:0] j_inc, j_dec, idx_inc, pos_dec;
  logic [LW-1:0] clip_len;

  assign j_inc   = j_q + CW'(1);
  assign j_dec   = j_q - CW'(1);
  assign idx_inc = idx_q + CW'(1);
  assign pos_dec = pos_q - CW'(1);

  // In both clip steps operand a holds the requested length and tmp_q the room.
  assign clip_len = alu_rsp_i.ge ? tmp_q[LW-1:0] : alu_req_o.a[LW-1:0];

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    used_d    = used_q;
    op_d      = op_q;
    count_d   = count_q;
    page_d    = page_q;
    len_d     = len_q;
    tmp_d     = tmp_q;
    idx_d     = idx_q;
    j_d       = j_q;
    pos_d     = pos_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    jp_d      = jp_q;
    stat_d    = stat_q;
    addr_d    = addr_q;
    out_load  = 1'b0;

    in_ready_o    = 1'b0;
    ram_wr_o      = '0;
    ram_raddr_o   = '0;
    alu_req_o.op  = ffea_pkg::ALU_ADD;
    alu_req_o.a   = '0;
    alu_req_o.b   = '0;

    case (state_q)
      S_BOOT: begin
        ram_wr_o.we          = 1'b1;
        ram_wr_o.addr        = '0;
        ram_wr_o.data.start  = ffea_pkg::RST_BASE;
        ram_wr_o.data.length = ffea_pkg::RST_LEN;
        state_d              = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d      = in_data_i.operation;
          count_d   = in_data_i.page_count;
          page_d    = in_data_i.free_page;
          stat_d    = ffea_pkg::ST_OK;
          addr_d    = '0;
          idx_d     = '0;
          cur_vld_d = 1'b0;
          case (in_data_i.operation)
            ffea_pkg::OP_INIT: begin
              state_d = S_INIT_ROOM;
            end
            ffea_pkg::OP_ALLOC: begin
              if (in_data_i.page_count == '0) begin
                stat_d  = ffea_pkg::ST_BAD;
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            ffea_pkg::OP_FREE: begin
              if (in_data_i.page_count == '0) begin
                stat_d  = ffea_pkg::ST_BAD;
                state_d = S_DONE;
              end else if (n_q == CW'(ffea_pkg::MAX_EXTENTS)) begin
                stat_d  = ffea_pkg::ST_FULL;
                state_d = S_DONE;
              end else begin
                state_d = S_CLIP_ROOM;
              end
            end
            default: begin
              stat_d  = ffea_pkg::ST_BAD;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_INIT_ROOM: begin
        alu_req_o.op = ffea_pkg::ALU_SUB;
        alu_req_o.a  = ffea_pkg::zx_len(ffea_pkg::PAGE_TOP);
        alu_req_o.b  = ffea_pkg::zx_page(cfg_i.base);
        tmp_d        = alu_rsp_i.res;
        state_d      = S_INIT_CLIP;
      end
      S_INIT_CLIP: begin
        alu_req_o.op = ffea_pkg::ALU_SUB;
        alu_req_o.a  = ffea_pkg::zx_len(cfg_i.pages);
        alu_req_o.b  = tmp_q;
        used_d       = '0;
        if (clip_len != '0) begin
          ram_wr_o.we          = 1'b1;
          ram_wr_o.addr        = '0;
          ram_wr_o.data.start  = cfg_i.base;
          ram_wr_o.data.length = clip_len;
          n_d                  = CW'(1);
        end else begin
          n_d = '0;
        end
        state_d = S_DONE;
      end
      S_CLIP_ROOM: begin
        alu_req_o.op = ffea_pkg::ALU_SUB;
        alu_req_o.a  = ffea_pkg::zx_len(ffea_pkg::PAGE_TOP);
        alu_req_o.b  = ffea_pkg::zx_page(page_q);
        tmp_d        = alu_rsp_i.res;
        state_d      = S_CLIP_LEN;
      end
      S_CLIP_LEN: begin
        alu_req_o.op = ffea_pkg::ALU_SUB;
        alu_req_o.a  = ffea_pkg::zx_len(count_q);
        alu_req_o.b  = tmp_q;
        len_d        = clip_len;
        idx_d        = '0;
        state_d      = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (idx_q == n_q) begin
          if (op_q == ffea_pkg::OP_ALLOC) begin
            stat_d  = ffea_pkg::ST_NO_SPACE;
            state_d = S_DONE;
          end else begin
            pos_d     = idx_q;
            cur_vld_d = 1'b0;
            state_d   = S_JP_SUM;
          end
        end else begin
          ram_raddr_o = idx_q[IW-1:0];
          state_d     = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cur_d = ram_rdata_i;
        if (op_q == ffea_pkg::OP_ALLOC) begin
          alu_req_o.op = ffea_pkg::ALU_SUB;
          alu_req_o.a  = ffea_pkg::zx_len(ram_rdata_i.length);
          alu_req_o.b  = ffea_pkg::zx_len(count_q);
          if (alu_rsp_i.ge) begin
            addr_d = ram_rdata_i.start;
            if (alu_rsp_i.eq) begin
              j_d     = idx_q;
              state_d = S_DN_RD;
            end else begin
              tmp_d   = alu_rsp_i.res;
              state_d = S_TRIM;
            end
          end else begin
            idx_d   = idx_inc;
            state_d = S_SCAN_RD;
          end
        end else begin
          alu_req_o.op = ffea_pkg::ALU_SUB;
          alu_req_o.a  = ffea_pkg::zx_page(ram_rdata_i.start);
          alu_req_o.b  = ffea_pkg::zx_page(page_q);
          if (!alu_rsp_i.ge) begin
            prev_d  = ram_rdata_i;
            idx_d   = idx_inc;
            state_d = S_SCAN_RD;
          end else if (alu_rsp_i.eq) begin
            state_d = S_USED_SUB;
          end else begin
            pos_d     = idx_q;
            cur_vld_d = 1'b1;
            state_d   = S_JP_SUM;
          end
        end
      end
      S_TRIM: begin
        alu_req_o.op         = ffea_pkg::ALU_ADD;
        alu_req_o.a          = ffea_pkg::zx_page(cur_q.start);
        alu_req_o.b          = ffea_pkg::zx_len(count_q);
        ram_wr_o.we          = 1'b1;
        ram_wr_o.addr        = idx_q[IW-1:0];
        ram_wr_o.data.start  = alu_rsp_i.res[PW-1:0];
        ram_wr_o.data.length = tmp_q[LW-1:0];
        state_d              = S_USED_ADD;
      end
      S_JP_SUM: begin
        alu_req_o.op = ffea_pkg::ALU_ADD;
        alu_req_o.a  = ffea_pkg::zx_page(prev_q.start);
        alu_req_o.b  = ffea_pkg::zx_len(prev_q.length);
        tmp_d        = alu_rsp_i.res;
        state_d      = S_JP_CMP;
      end
      S_JP_CMP: begin
        alu_req_o.op = ffea_pkg::ALU_SUB;
        alu_req_o.a  = tmp_q;
        alu_req_o.b  = ffea_pkg::zx_page(page_q);
        jp_d         = (pos_q != '0) && alu_rsp_i.eq;
        state_d      = S_JN_SUM;
      end
      S_JN_SUM: begin
        alu_req_o.op = ffea_pkg::ALU_ADD;
        alu_req_o.a  = ffea_pkg::zx_page(page_q);
        alu_req_o.b  = ffea_pkg::zx_len(len_q);
        tmp_d        = alu_rsp_i.res;
        state_d      = S_JN_CMP;
      end
      S_JN_CMP: begin
        alu_req_o.op = ffea_pkg::ALU_SUB;
        alu_req_o.a  = tmp_q;
        alu_req_o.b  = ffea_pkg::zx_page(cur_q.start);
        if (jp_q && cur_vld_q && alu_rsp_i.eq) begin
          state_d = S_MRG_A;
        end else if (jp_q) begin
          state_d = S_MRG_P;
        end else if (cur_vld_q && alu_rsp_i.eq) begin
          state_d = S_MRG_N;
        end else begin
          j_d     = n_q;
          state_d = S_UP_RD;
        end
      end
      S_MRG_A: begin
        alu_req_o.op = ffea_pkg::ALU_ADD;
        alu_req_o.a  = ffea_pkg::zx_len(prev_q.length);
        alu_req_o.b  = ffea_pkg::zx_len(len_q);
        tmp_d        = alu_rsp_i.res;
        state_d      = S_MRG_B;
      end
      S_MRG_B: begin
        alu_req_o.op         = ffea_pkg::ALU_ADD;
        alu_req_o.a          = tmp_q;
        alu_req_o.b          = ffea_pkg::zx_len(cur_q.length);
        ram_wr_o.we          = 1'b1;
        ram_wr_o.addr        = pos_dec[IW-1:0];
        ram_wr_o.data.start  = prev_q.start;
        ram_wr_o.data.length = alu_rsp_i.res[LW-1:0];
        j_d                  = pos_q;
        state_d              = S_DN_RD;
      end
      S_MRG_P: begin
        alu_req_o.op         = ffea_pkg::ALU_ADD;
        alu_req_o.a          = ffea_pkg::zx_len(prev_q.length);
        alu_req_o.b          = ffea_pkg::zx_len(len_q);
        ram_wr_o.we          = 1'b1;
        ram_wr_o.addr        = pos_dec[IW-1:0];
        ram_wr_o.data.start  = prev_q.start;
        ram_wr_o.data.length = alu_rsp_i.res[LW-1:0];
        state_d              = S_USED_SUB;
      end
      S_MRG_N: begin
        alu_req_o.op         = ffea_pkg::ALU_ADD;
        alu_req_o.a          = ffea_pkg::zx_len(cur_q.length);
        alu_req_o.b          = ffea_pkg::zx_len(len_q);
        ram_wr_o.we          = 1'b1;
        ram_wr_o.addr        = pos_q[IW-1:0];
        ram_wr_o.data.start  = page_q;
        ram_wr_o.data.length = alu_rsp_i.res[LW-1:0];
        state_d              = S_USED_SUB;
      end
      S_DN_RD: begin
        if (j_inc < n_q) begin
          ram_raddr_o = j_inc[IW-1:0];
          state_d     = S_DN_WR;
        end else begin
          n_d = n_q - CW'(1);
          if (op_q == ffea_pkg::OP_ALLOC) begin
            state_d = S_USED_ADD;
          end else begin
            state_d = S_USED_SUB;
          end
        end
      end
      S_DN_WR: begin
        ram_wr_o.we   = 1'b1;
        ram_wr_o.addr = j_q[IW-1:0];
        ram_wr_o.data = ram_rdata_i;
        j_d           = j_inc;
        state_d       = S_DN_RD;
      end
      S_UP_RD: begin
        if (j_q > pos_q) begin
          ram_raddr_o = j_dec[IW-1:0];
          state_d     = S_UP_WR;
        end else begin
          ram_wr_o.we          = 1'b1;
          ram_wr_o.addr        = pos_q[IW-1:0];
          ram_wr_o.data.start  = page_q;
          ram_wr_o.data.length = len_q;
          n_d                  = n_q + CW'(1);
          state_d              = S_USED_SUB;
        end
      end
      S_UP_WR: begin
        ram_wr_o.we   = 1'b1;
        ram_wr_o.addr = j_q[IW-1:0];
        ram_wr_o.data = ram_rdata_i;
        j_d           = j_dec;
        state_d       = S_UP_RD;
      end
      S_USED_ADD: begin
        alu_req_o.op = ffea_pkg::ALU_ADD;
        alu_req_o.a  = ffea_pkg::zx_len(used_q);
        alu_req_o.b  = ffea_pkg::zx_len(count_q);
        if (alu_rsp_i.res > ffea_pkg::zx_len(ffea_pkg::PAGE_TOP)) begin
          used_d = ffea_pkg::PAGE_TOP;
        end else begin
          used_d = alu_rsp_i.res[LW-1:0];
        end
        state_d = S_DONE;
      end
      S_USED_SUB: begin
        alu_req_o.op = ffea_pkg::ALU_SUB;
        alu_req_o.a  = ffea_pkg::zx_len(used_q);
        alu_req_o.b  = ffea_pkg::zx_len(len_q);
        used_d       = alu_rsp_i.ge ? alu_rsp_i.res[LW-1:0] : '0;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: holds one finished result until the sink takes it.
  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    if (out_load) begin
      out_vld_d          = 1'b1;
      out_d.status       = stat_q;
      out_d.address_page = addr_q;
      out_d.used_pages   = used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_BOOT;
      n_q       <= (ffea_pkg::RST_LEN != '0) ? CW'(1) : '0;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    count_q   <= count_d;
    page_q    <= page_d;
    len_q     <= len_d;
    tmp_q     <= tmp_d;
    idx_q     <= idx_d;
    j_q       <= j_d;
    pos_q     <= pos_d;
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    cur_vld_q <= cur_vld_d;
    jp_q      <= jp_d;
    stat_q    <= stat_d;
    addr_q    <= addr_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/first_fit_extent_allocator_unit.sv
// First-fit page extent allocator. Requests (init, allocate, free) arrive as
// one transfer each on the in_valid_i/in_ready_o channel, and each gives one
// result transfer on out_valid_o/out_ready_i with a status, the allocated
// start page and the running count of pages in use. Two registers, the region
// base page and the region size, are written through the cfg_we_i port and
// take effect at the next init request.
// One request is worked at a time; in_ready_o is high only while the sequencer
// is idle. The table has one write port and one read port with registered
// data, and the sequencer walks it one entry at a time, so the time per
// request is set by the table walk: an allocate scans to the first extent
// that fits and trims it or removes it by shifting later entries down, and a
// free scans to its insert position, then joins the range with its neighbors
// or shifts later entries up to make room.
// After reset the block writes the initial extent into the table and raises
// in_ready_o in the cycle after that write. A finished result sits in an
// output register; while the receiver stalls, the block can still take and
// work the next request, and holds that second result until the first one
// is taken.
module first_fit_extent_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffea_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ffea_pkg::LEN_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ffea_pkg::req_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ffea_pkg::rsp_t                 out_data_o
);

  ffea_pkg::cfg_t     cfg_q;
  ffea_pkg::ram_wr_t  ram_wr;
  logic [ffea_pkg::IDX_W-1:0] ram_raddr;
  ffea_pkg::ext_t     ram_rdata;
  ffea_pkg::alu_req_t alu_req;
  ffea_pkg::alu_rsp_t alu_rsp;

  // Configuration registers. They are only sampled by an init request, so a
  // write simply lands here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= ffea_pkg::RST_BASE;
      cfg_q.pages <= ffea_pkg::RST_PAGES;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ffea_pkg::CFG_BASE: begin
          cfg_q.base <= cfg_data_i[ffea_pkg::PAGE_W-1:0];
        end
        ffea_pkg::CFG_PAGES: begin
          cfg_q.pages <= cfg_data_i;
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Sequencer: owns the request state, the table walk and the output register.
  ffea_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp)
  );

  // Sorted free-extent table.
  ffea_extent_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The one adder/comparator used for the page and length sums, clips and table compares.
  ffea_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

endmodule
